@@ rtl/rvn_pkg.sv @@
// Shared constants, widths and register codes for the ridged value noise block.
// No dependencies; compile first.
package rvn_pkg;

  localparam int RVN_MAX_OCTAVES = 8;
  localparam int RVN_CELL_BITS   = 12;
  localparam int RVN_FRAC_BITS   = 16;

  localparam int COORD_W    = 32;
  localparam int RIDGE_W    = 17;
  localparam int NOISE_W    = 16;
  localparam int SEED_W     = 32;
  localparam int CELLS_W    = 13;
  localparam int OCT_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int LANE_STAGES = 5;
  localparam int DIV_BPS     = 4;
  localparam int SEED_STEP   = 97;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_S   = 32'd2246822519;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

  localparam logic [RIDGE_W-1:0] RIDGE_ONE = 17'd65536;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NOISE_SEED   = 2'd0,
    REG_WRAP_CELLS   = 2'd1,
    REG_OCTAVE_COUNT = 2'd2
  } cfg_reg_e;

endpackage

@@ rtl/rvn_in_if.sv @@
// Input channel: one coordinate pair per item with valid/ready.
// Depends on rvn_pkg.
interface rvn_in_if import rvn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] u_coord;
  logic signed [COORD_W-1:0] v_coord;

  modport source (output valid, output u_coord, output v_coord, input ready);
  modport sink   (input valid, input u_coord, input v_coord, output ready);
endinterface

@@ rtl/rvn_out_if.sv @@
// Output channel: ridged noise and first octave noise per item with valid/ready.
// Depends on rvn_pkg.
interface rvn_out_if import rvn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RIDGE_W-1:0] ridge_value;
  logic [NOISE_W-1:0] base_noise;

  modport source (output valid, output ridge_value, output base_noise, input ready);
  modport sink   (input valid, input ridge_value, input base_noise, output ready);
endinterface

@@ rtl/rvn_lane.sv @@
// One octave lane: lattice corners, integer hash, smoothstep and bilinear blend,
// five register stages. Depends on rvn_pkg.
module rvn_lane import rvn_pkg::*; #(
  parameter int FRAC_BITS = RVN_FRAC_BITS,
  parameter int CELL_BITS = RVN_CELL_BITS,
  parameter int OCTAVE    = 0
) (
  input  logic                      clk_i,
  input  logic [LANE_STAGES-1:0]    en_i,
  input  logic signed [COORD_W-1:0] u_i,
  input  logic signed [COORD_W-1:0] v_i,
  input  logic [CELL_BITS-1:0]      u_base_i,
  input  logic [CELL_BITS:0]        cells_i,
  input  logic [SEED_W-1:0]         seed_i,
  output logic [NOISE_W-1:0]        noise_o
);

  localparam int F  = FRAC_BITS;
  localparam int LW = NOISE_W + F + 2;
  localparam logic [F:0]   ONE   = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0] THREE = (F+2)'(3) << F;

  // stage A: lattice indices and fractions
  logic signed [63:0] cu, cv;
  logic [63:0] u_hi, u_sub;
  logic [31:0] u0_a, u1_a, u1_inc, n_lat;
  logic [31:0] u0_q, u1_q, v0_q, seed_q;
  logic [F-1:0] fu_q, fv_q;

  assign cu     = 64'(u_i) <<< OCTAVE;
  assign cv     = 64'(v_i) <<< OCTAVE;
  assign u_hi   = 64'(u_base_i) << OCTAVE;
  assign u_sub  = (cu >> F) & ((64'd1 << OCTAVE) - 64'd1);
  assign u0_a   = 32'(u_hi + u_sub);
  assign n_lat  = 32'(64'(cells_i) << OCTAVE);
  assign u1_inc = u0_a + 32'd1;
  assign u1_a   = (u1_inc == n_lat) ? '0 : u1_inc;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u0_q   <= u0_a;
      u1_q   <= u1_a;
      v0_q   <= cv[F+31:F];
      fu_q   <= cu[F-1:0];
      fv_q   <= cv[F-1:0];
      seed_q <= seed_i + 32'(SEED_STEP * OCTAVE);
    end
  end

  // stage B: first hash products, squared fractions
  logic [31:0] pu0_q, pu1_q, pv0_q, pv1_q, ps_q;
  logic [2*F-1:0] squ, sqv;
  logic [F-1:0] t2u_q, t2v_q, fu_b_q, fv_b_q;

  assign squ = (2*F)'(fu_q) * (2*F)'(fu_q);
  assign sqv = (2*F)'(fv_q) * (2*F)'(fv_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pu0_q  <= u0_q * HASH_MUL_X;
      pu1_q  <= u1_q * HASH_MUL_X;
      pv0_q  <= v0_q * HASH_MUL_Y;
      pv1_q  <= (v0_q + 32'd1) * HASH_MUL_Y;
      ps_q   <= seed_q * HASH_MUL_S;
      t2u_q  <= squ[2*F-1:F];
      t2v_q  <= sqv[2*F-1:F];
      fu_b_q <= fu_q;
      fv_b_q <= fv_q;
    end
  end

  // stage C: hash mix multiply, smoothstep weights
  logic [31:0] h_a, h_b, h_c, h_d;
  logic [31:0] g_a_q, g_b_q, g_c_q, g_d_q;
  logic [F+1:0] wu, wv;
  logic [2*F+3:0] pwu, pwv;
  logic [F:0] su_q, sv_q;

  assign h_a = pu0_q ^ pv0_q ^ ps_q;
  assign h_b = pu1_q ^ pv0_q ^ ps_q;
  assign h_c = pu0_q ^ pv1_q ^ ps_q;
  assign h_d = pu1_q ^ pv1_q ^ ps_q;
  assign wu  = THREE - (F+2)'({fu_b_q, 1'b0});
  assign wv  = THREE - (F+2)'({fv_b_q, 1'b0});
  assign pwu = (2*F+4)'(t2u_q) * (2*F+4)'(wu);
  assign pwv = (2*F+4)'(t2v_q) * (2*F+4)'(wv);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      g_a_q <= (h_a ^ (h_a >> 13)) * HASH_MUL_MIX;
      g_b_q <= (h_b ^ (h_b >> 13)) * HASH_MUL_MIX;
      g_c_q <= (h_c ^ (h_c >> 13)) * HASH_MUL_MIX;
      g_d_q <= (h_d ^ (h_d >> 13)) * HASH_MUL_MIX;
      su_q  <= pwu[2*F:F];
      sv_q  <= pwv[2*F:F];
    end
  end

  // stage D: corner values are the top half of the mixed hash; blend along u
  logic [F:0] omu;
  logic [LW-1:0] lo_sum, hi_sum;
  logic [NOISE_W-1:0] lo_q, hi_q;
  logic [F:0] sv_d_q;

  assign omu    = ONE - su_q;
  assign lo_sum = LW'(g_a_q[31:16]) * LW'(omu) + LW'(g_b_q[31:16]) * LW'(su_q);
  assign hi_sum = LW'(g_c_q[31:16]) * LW'(omu) + LW'(g_d_q[31:16]) * LW'(su_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      lo_q   <= lo_sum[F+NOISE_W-1:F];
      hi_q   <= hi_sum[F+NOISE_W-1:F];
      sv_d_q <= sv_q;
    end
  end

  // stage E: blend along v
  logic [F:0] omv;
  logic [LW-1:0] n_sum;
  logic [NOISE_W-1:0] noise_q;

  assign omv   = ONE - sv_d_q;
  assign n_sum = LW'(lo_q) * LW'(omv) + LW'(hi_q) * LW'(sv_d_q);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      noise_q <= n_sum[F+NOISE_W-1:F];
    end
  end

  assign noise_o = noise_q;

endmodule

@@ rtl/ridged_value_noise_fbm_top.sv @@
// Ridged fractal value noise on a ring-wrapped lattice, fully pipelined.
// Depends on rvn_pkg, rvn_in_if, rvn_out_if and rvn_lane.
//
//   channel   dir  fields                         handshake
//   in_i      in   u_coord[31:0], v_coord[31:0]   valid/ready
//   out_o     out  ridge_value[16:0], base_noise  valid/ready
//   cfg       in   cfg_addr_i, cfg_wdata_i        cfg_we_i, no back-pressure
//
// One item per cycle sustained while out_o is ready. Items pass an input stage,
// MS = ceil((32-FRAC_BITS)/4) stages of the u-ring remainder, the rvn_lane stages,
// a ridge stage, a sum stage and DS = ceil((17+MAX_OCTAVES)/4) stages of the
// normalizing division. Reset clears the valid bits and loads the register defaults.
// Every full stage holds when the one after it is full and stalled, so the input
// keeps accepting until all stages are occupied.
module ridged_value_noise_fbm_top import rvn_pkg::*; #(
  parameter int MAX_OCTAVES = RVN_MAX_OCTAVES,
  parameter int CELL_BITS   = RVN_CELL_BITS,
  parameter int FRAC_BITS   = RVN_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  rvn_in_if.sink                in_i,
  rvn_out_if.source             out_o
);

  localparam int W_U   = COORD_W - FRAC_BITS;
  localparam int MS    = (W_U + DIV_BPS - 1) / DIV_BPS;
  localparam int MW    = MS * DIV_BPS;
  localparam int CW    = CELL_BITS + 1;
  localparam int MRW   = CELL_BITS + 2;
  localparam int LS    = LANE_STAGES;
  localparam int AW    = RIDGE_W + MAX_OCTAVES;
  localparam int DS    = (AW + DIV_BPS - 1) / DIV_BPS;
  localparam int DW    = DS * DIV_BPS;
  localparam int DRW   = MAX_OCTAVES + 1;
  localparam int OW    = $clog2(MAX_OCTAVES + 1);
  localparam int NP    = (MAX_OCTAVES + 1) / 2;
  localparam int EXT_W = (CELLS_W > CW) ? CELLS_W : CW;
  localparam int OEX_W = (OCT_W > OW) ? OCT_W : OW;

  localparam int S_MOD  = 1;
  localparam int S_LANE = S_MOD + MS;
  localparam int S_RID  = S_LANE + LS;
  localparam int S_SUM  = S_RID + 1;
  localparam int S_DIV  = S_SUM + 1;
  localparam int NS     = S_DIV + DS;

  localparam logic [EXT_W-1:0] CELLS_MAX = EXT_W'(1) << CELL_BITS;
  localparam logic [OEX_W-1:0] OCT_MAX   = OEX_W'(MAX_OCTAVES);

  // ---------------------------------------------------------------- config
  logic [SEED_W-1:0]  seed_q;
  logic [CELLS_W-1:0] wrap_q;
  logic [OCT_W-1:0]   oct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      wrap_q <= CELLS_W'(16);
      oct_q  <= OCT_W'(4);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_NOISE_SEED:   seed_q <= cfg_wdata_i[SEED_W-1:0];
        REG_WRAP_CELLS:   wrap_q <= cfg_wdata_i[CELLS_W-1:0];
        REG_OCTAVE_COUNT: oct_q  <= cfg_wdata_i[OCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp cell count to 1 .. 2^CELL_BITS and octaves to MAX_OCTAVES.
  logic [CW-1:0] cells;
  logic [OW-1:0] oct_eff;
  logic [EXT_W-1:0] wrap_ext;
  logic [OEX_W-1:0] oct_ext;

  assign wrap_ext = EXT_W'(wrap_q);
  assign oct_ext  = OEX_W'(oct_q);
  assign cells    = (wrap_q == '0) ? CW'(1) :
                    (wrap_ext > CELLS_MAX) ? CW'(CELLS_MAX) : CW'(wrap_ext);
  assign oct_eff  = (oct_ext > OCT_MAX) ? OW'(OCT_MAX) : OW'(oct_ext);

  // ------------------------------------------------------------- handshake
  // A stage advances when it is empty or the stage after it advances.
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_o.ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_i.valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  assign in_i.ready = en[0];

  // ----------------------------------------------------------- input stage
  logic signed [COORD_W-1:0] u_in_q, v_in_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u_in_q <= in_i.u_coord;
      v_in_q <= in_i.v_coord;
    end
  end

  // Magnitude of the integer part of u; the sign is folded back after the
  // remainder is known.
  logic           u_neg;
  logic [W_U-1:0] u_mag;

  assign u_neg = u_in_q[COORD_W-1];
  assign u_mag = u_neg ? (~u_in_q[COORD_W-1:FRAC_BITS] + 1'b1) : u_in_q[COORD_W-1:FRAC_BITS];

  // ------------------------------------------- u remainder modulo the ring
  logic [MRW-1:0] mrem_in [MS];
  logic [MW-1:0]  mdvd_in [MS];
  logic           mneg_in [MS];
  logic signed [COORD_W-1:0] mu_in [MS], mv_in [MS];
  logic [MRW-1:0] mrem_q [MS];
  logic [MW-1:0]  mdvd_q [MS];
  logic           mneg_q [MS];
  logic signed [COORD_W-1:0] mu_q [MS], mv_q [MS];

  for (genvar i = 0; i < MS; i++) begin : g_mod
    logic [MRW-1:0] r;
    logic [MW-1:0]  d;

    if (i == 0) begin : g_first
      assign mrem_in[i] = '0;
      assign mdvd_in[i] = MW'(u_mag);
      assign mneg_in[i] = u_neg;
      assign mu_in[i]   = u_in_q;
      assign mv_in[i]   = v_in_q;
    end else begin : g_next
      assign mrem_in[i] = mrem_q[i-1];
      assign mdvd_in[i] = mdvd_q[i-1];
      assign mneg_in[i] = mneg_q[i-1];
      assign mu_in[i]   = mu_q[i-1];
      assign mv_in[i]   = mv_q[i-1];
    end

    // Shift in one dividend bit at a time and subtract the cell count.
    always_comb begin
      r = mrem_in[i];
      d = mdvd_in[i];
      for (int b = 0; b < DIV_BPS; b++) begin
        r = {r[MRW-2:0], d[MW-1]};
        d = d << 1;
        if (r >= MRW'(cells)) r = r - MRW'(cells);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[S_MOD+i]) begin
        mrem_q[i] <= r;
        mdvd_q[i] <= d;
        mneg_q[i] <= mneg_in[i];
        mu_q[i]   <= mu_in[i];
        mv_q[i]   <= mv_in[i];
      end
    end
  end

  // Non-negative remainder of the floor index.
  logic [CW-1:0]        rem_w;
  logic [CELL_BITS-1:0] u_base;

  assign rem_w  = CW'(mrem_q[MS-1]);
  assign u_base = (mneg_q[MS-1] && rem_w != '0) ? CELL_BITS'(cells - rem_w)
                                                : CELL_BITS'(rem_w);

  // ------------------------------------------------------------ octave lanes
  logic [NOISE_W-1:0] lane_n [MAX_OCTAVES];

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
    rvn_lane #(
      .FRAC_BITS (FRAC_BITS),
      .CELL_BITS (CELL_BITS),
      .OCTAVE    (k)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (en[S_LANE +: LS]),
      .u_i      (mu_q[MS-1]),
      .v_i      (mv_q[MS-1]),
      .u_base_i (u_base),
      .cells_i  (cells),
      .seed_i   (seed_q),
      .noise_o  (lane_n[k])
    );
  end

  // ------------------------------------------- ridge fold and weighted terms
  logic [AW-1:0] term [MAX_OCTAVES];
  logic [AW-1:0] psum_q [NP];
  logic [NOISE_W-1:0] rbase_q;

  always_comb begin
    logic [RIDGE_W-1:0] dev;
    logic [RIDGE_W-1:0] rk;
    for (int k = 0; k < MAX_OCTAVES; k++) begin
      dev = {lane_n[k], 1'b0};
      // above one half the ridge falls back toward zero
      rk  = lane_n[k][NOISE_W-1] ? RIDGE_W'((RIDGE_W+1)'(2 * 65536) - (RIDGE_W+1)'(dev))
                                 : dev;
      term[k] = (oct_eff > OW'(k)) ? (AW'(rk) << (MAX_OCTAVES - 1 - k)) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_RID]) begin
      for (int j = 0; j < NP; j++) begin
        if (2 * j + 1 < MAX_OCTAVES) psum_q[j] <= term[2*j] + term[2*j+1];
        else                         psum_q[j] <= term[2*j];
      end
      rbase_q <= lane_n[0];
    end
  end

  // ---------------------------------------- total, pre-shift of denominator
  // den = 2^(M-oct) * (2^oct - 1): drop the power of two here.
  logic [AW-1:0] acc;
  logic [DW-1:0] sx_q;
  logic [NOISE_W-1:0] sbase_q;

  always_comb begin
    acc = '0;
    for (int j = 0; j < NP; j++) acc = acc + psum_q[j];
  end

  always_ff @(posedge clk_i) begin
    if (en[S_SUM]) begin
      sx_q    <= DW'(acc >> (OW'(MAX_OCTAVES) - oct_eff));
      sbase_q <= rbase_q;
    end
  end

  // ------------------------------------------- divide by 2^oct - 1
  logic [DRW-1:0] divisor;
  assign divisor = (oct_eff == '0) ? DRW'(1) : ((DRW'(1) << oct_eff) - DRW'(1));

  logic [DW-1:0]      dq_in [DS];
  logic [DRW-1:0]     dr_in [DS];
  logic [NOISE_W-1:0] db_in [DS];
  logic [DW-1:0]      dq_q [DS];
  logic [DRW-1:0]     dr_q [DS];
  logic [NOISE_W-1:0] db_q [DS];

  for (genvar i = 0; i < DS; i++) begin : g_div
    logic [DRW-1:0] r;
    logic [DW-1:0]  q;

    if (i == 0) begin : g_first
      assign dq_in[i] = sx_q;
      assign dr_in[i] = '0;
      assign db_in[i] = sbase_q;
    end else begin : g_next
      assign dq_in[i] = dq_q[i-1];
      assign dr_in[i] = dr_q[i-1];
      assign db_in[i] = db_q[i-1];
    end

    // Dividend bits leave at the top, quotient bits enter at the bottom.
    always_comb begin
      r = dr_in[i];
      q = dq_in[i];
      for (int b = 0; b < DIV_BPS; b++) begin
        r = {r[DRW-2:0], q[DW-1]};
        q = {q[DW-2:0], 1'b0};
        if (r >= divisor) begin
          r    = r - divisor;
          q[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[S_DIV+i]) begin
        dq_q[i] <= q;
        dr_q[i] <= r;
        db_q[i] <= db_in[i];
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign out_o.valid       = vld_q[NS-1];
  assign out_o.ridge_value = dq_q[DS-1][RIDGE_W-1:0];
  assign out_o.base_noise  = db_q[DS-1];

  // ------------------------------------------------------------ assertions
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted item did not enter the first stage");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> in_i.ready)
    else $error("input stalled while first stage is empty");

  a_ridge_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.ridge_value <= RIDGE_ONE)
    else $error("ridge value above one");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-2] && vld_q[NS-1] && !out_o.ready |=> vld_q[NS-2])
    else $error("item lost behind a stalled output");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for ridged_value_noise_fbm_top: predicts ridged fbm noise
// per accepted coordinate item and compares it with every output item.
// Depends on rvn_pkg, rvn_in_if, rvn_out_if and the block itself.
module tb_top;
  import rvn_pkg::*;

  localparam int LATENCY   = 19;
  localparam int DRAIN     = 4 * LATENCY;
  localparam int LIMIT     = 900000;
  localparam int RAND_ITEMS = 150;

  // Noise predictor with its own register copy and a queue of expected items.
  class noise_scoreboard;
    logic [SEED_W-1:0]  seed_q;
    logic [CELLS_W-1:0] cells_q;
    logic [OCT_W-1:0]   oct_q;
    logic [RIDGE_W-1:0] ridge_fifo[$];
    logic [NOISE_W-1:0] base_fifo[$];

    function new();
      seed_q  = '0;
      cells_q = 13'd16;
      oct_q   = 4'd4;
    endfunction

    function automatic logic [15:0] corner(logic [31:0] x, logic [31:0] y, logic [31:0] s);
      logic [31:0] h;
      h = (x * HASH_MUL_X) ^ (y * HASH_MUL_Y) ^ (s * HASH_MUL_S);
      h = (h ^ (h >> 13)) * HASH_MUL_MIX;
      h = h ^ (h >> 16);
      return h[31:16];
    endfunction

    function automatic longint smooth(longint t);
      longint t2;
      t2 = (t * t) >>> RVN_FRAC_BITS;
      return (t2 * (3 * 65536 - 2 * t)) >>> RVN_FRAC_BITS;
    endfunction

    function automatic longint octave(longint u, longint v, int k, longint cells);
      longint cu, cv, n, iu, iv, fu, fv, su, sv, r, lo, hi;
      logic [31:0] u0, u1, v0, v1, s;
      longint a, b, c, d;
      cu = u <<< k;
      cv = v <<< k;
      n  = cells <<< k;
      iu = cu >>> RVN_FRAC_BITS;  // arithmetic shift gives the true floor
      iv = cv >>> RVN_FRAC_BITS;
      fu = cu & 64'hFFFF;
      fv = cv & 64'hFFFF;
      su = smooth(fu);
      sv = smooth(fv);
      r = iu % n;
      if (r < 0) r += n;
      u0 = r[31:0];
      u1 = 32'((r + 1) % n);
      v0 = iv[31:0];
      v1 = v0 + 32'd1;
      s  = seed_q + 32'(k) * 32'(SEED_STEP);
      a = corner(u0, v0, s);
      b = corner(u1, v0, s);
      c = corner(u0, v1, s);
      d = corner(u1, v1, s);
      lo = (a * (65536 - su) + b * su) >>> RVN_FRAC_BITS;
      hi = (c * (65536 - su) + d * su) >>> RVN_FRAC_BITS;
      return (lo * (65536 - sv) + hi * sv) >>> RVN_FRAC_BITS;
    endfunction

    // Predict one accepted coordinate item and queue it.
    function void note_coord(logic signed [31:0] u, logic signed [31:0] v);
      longint cells, n, dev, r, acc, den, ridge, base;
      int oct;
      cells = cells_q;
      if (cells == 0) cells = 1;
      if (cells > (1 << RVN_CELL_BITS)) cells = 1 << RVN_CELL_BITS;
      oct = oct_q;
      if (oct > RVN_MAX_OCTAVES) oct = RVN_MAX_OCTAVES;
      base = octave(longint'(u), longint'(v), 0, cells);
      acc = 0;
      for (int k = 0; k < oct; k++) begin
        n = (k == 0) ? base : octave(longint'(u), longint'(v), k, cells);
        dev = 2 * n - 65536;
        r = 65536 - (dev < 0 ? -dev : dev);
        acc += r <<< (RVN_MAX_OCTAVES - 1 - k);
      end
      ridge = 0;
      if (oct > 0) begin
        den = (longint'(1) <<< RVN_MAX_OCTAVES) - (longint'(1) <<< (RVN_MAX_OCTAVES - oct));
        ridge = acc / den;
      end
      ridge_fifo = {ridge_fifo, ridge[RIDGE_W-1:0]};
      base_fifo  = {base_fifo, base[NOISE_W-1:0]};
    endfunction

    // Compare one output item with the oldest prediction; return "" on match.
    function string check_noise(logic [RIDGE_W-1:0] ridge, logic [NOISE_W-1:0] base);
      logic [RIDGE_W-1:0] er;
      logic [NOISE_W-1:0] eb;
      string msg;
      if (ridge_fifo.size() == 0) return "output item with nothing expected";
      er = ridge_fifo.pop_front();
      eb = base_fifo.pop_front();
      msg = "";
      if (ridge !== er) msg = $sformatf("ridge_value %0d, expected %0d", ridge, er);
      if (base !== eb) msg = {msg, $sformatf(" base_noise %0d, expected %0d", base, eb)};
      return msg;
    endfunction

    function int pending();
      return ridge_fifo.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  rvn_in_if  coord_ch();
  rvn_out_if noise_ch();

  ridged_value_noise_fbm_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (coord_ch.sink),
    .out_o       (noise_ch.source)
  );

  noise_scoreboard sb = new();
  int  mismatches = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;  // burst mode: neither side idles

  initial begin
    coord_ch.valid   = 1'b0;
    coord_ch.u_coord = '0;
    coord_ch.v_coord = '0;
    noise_ch.ready   = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // Gap length: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Note every accepted coordinate item; check every accepted output item.
  always @(posedge clk_i) begin
    if (rst_ni && coord_ch.valid && coord_ch.ready)
      sb.note_coord(coord_ch.u_coord, coord_ch.v_coord);
    if (rst_ni && noise_ch.valid && noise_ch.ready) begin
      string msg;
      msg = sb.check_noise(noise_ch.ridge_value, noise_ch.base_noise);
      if (msg != "") report(msg);
    end
  end

  // Output side: hold ready for a random run, then drop it for a random gap.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      noise_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      g = pick_gap();
      if (g > 0) begin
        noise_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // Send one coordinate item; valid stays high between back-to-back items.
  task automatic send_coord(logic [31:0] u, logic [31:0] v);
    int g;
    g = pick_gap();
    if (g > 0) begin
      coord_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    coord_ch.valid   <= 1'b1;
    coord_ch.u_coord <= u;
    coord_ch.v_coord <= v;
    do @(posedge clk_i); while (!coord_ch.ready);
  endtask

  // Write all three registers back to back, then drop the write enable.
  task automatic write_regs(logic [31:0] seed, logic [12:0] cells, logic [3:0] oct);
    cfg_we_i <= 1'b1; cfg_addr_i <= REG_NOISE_SEED;   cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_addr_i <= REG_WRAP_CELLS;   cfg_wdata_i <= 32'(cells);
    @(posedge clk_i);
    cfg_addr_i <= REG_OCTAVE_COUNT; cfg_wdata_i <= 32'(oct);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.seed_q  = seed;
    sb.cells_q = cells;
    sb.oct_q   = oct;
  endtask

  // Hold until every prediction is matched, then let the pipeline settle.
  task automatic drain();
    coord_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
    endcase
  endfunction

  logic [31:0] seeds[9];
  logic [12:0] cellss[9];
  logic [3:0]  octs[9];

  initial begin
    logic [31:0] edge_vals[8];
    edge_vals = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0000_8000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0001_0000};
    seeds  = '{32'h0, 32'hFFFF_FFFF, $urandom(), 32'h1234_5678, $urandom(),
               $urandom(), 32'hDEAD_BEEF, $urandom(), $urandom()};
    cellss = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd4097,
               13'($urandom_range(1, 64)), 13'd3, 13'd16, 13'($urandom_range(1, 4096))};
    octs   = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd9,
               4'($urandom_range(1, 8)), 4'd2, 4'd4, 4'd7};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: coordinate extremes and negatives under the reset settings.
    for (int i = 0; i < 8; i++) send_coord(edge_vals[i], edge_vals[7 - i]);
    for (int i = 0; i < 8; i++) send_coord(edge_vals[i], edge_vals[i]);
    send_coord(32'hFFF0_0000, 32'h0010_0000);  // u wraps below zero
    send_coord(32'h0010_0000, 32'hFFF0_8000);
    drain();

    for (int p = 0; p < 9; p++) begin
      write_regs(seeds[p], cellss[p], octs[p]);
      if (p == 0) begin
        // Directed again: zero cells and zero octaves.
        for (int i = 0; i < 4; i++) send_coord(edge_vals[i], edge_vals[i + 4]);
      end
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_coord(rand_coord(), rand_coord());
      end
      no_idle = 1'b0;
      drain();
    end

    if (mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
